FILE: rtl/plrc_pkg.sv
package plrc_pkg;

    localparam int LEVEL_W        = 3;
    localparam int OPCODE_W       = 3;
    localparam int CNT_W          = 32;
    localparam int TIME_W         = 64;
    localparam int NUM_LEVELS_DEF = 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_START   = 3'd0,
        OP_UPDATE  = 3'd1,
        OP_RD_LVL  = 3'd2,
        OP_RD_ON   = 3'd3,
        OP_RD_OFF  = 3'd4
    } t_opcode;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [LEVEL_W-1:0]  level;
        logic                pwr_on;
        logic [TIME_W-1:0]   time_ns;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0]  entry_cnt;
        logic [TIME_W-1:0] resid_ns;
        logic [TIME_W-1:0] stamp_ns;
    } t_out_item;

endpackage

FILE: rtl/plrc_ram.sv
module plrc_ram #(
    parameter  int WIDTH  = 64,
    parameter  int DEPTH  = 8,
    localparam int AddrW  = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AddrW-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/power_level_residency_counters_unit.sv
// Residency counters for performance levels and for power on/off.
//
// Input channel: i_valid / o_stall with payload i_data (opcode, level, power flag,
// timestamp). Output channel: o_valid / i_stall with payload o_data. A transfer
// happens at a rising edge where valid is high and stall is low.
// Every accepted event produces exactly one result; start and update events
// return zeros, read events return the selected count, total and last-entry stamp.
//
// Per-level statistics sit in two synchronous RAMs: one holds entry count and
// entry stamp, the other the accumulated time. An event reads both in its accept
// cycle and writes them back in the execute state, so the block takes no new
// event until it is done with the last one. The result is loaded into the output
// register when the execute state ends; if that register still
// holds an untaken result, the block waits there and keeps o_stall high.
//
// Reset clears all control state, the power-state totals and the per-entry valid
// bits; an entry that has never been written reads as zero, so no clearing pass
// is needed and the block accepts events straight after reset.
module power_level_residency_counters_unit
    import plrc_pkg::*;
#(
    parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    localparam int IdxW  = $clog2(NUM_LEVELS);
    localparam int ExtW  = ((IdxW > LEVEL_W) ? IdxW : LEVEL_W) + 1;
    localparam int EntW  = CNT_W + TIME_W;

    t_state r_state, n_state;

    t_in_item          r_item;
    logic [IdxW-1:0]   r_e_addr, r_s_addr;
    logic [NUM_LEVELS-1:0] r_e_vld, r_s_vld;

    logic [LEVEL_W-1:0] r_cur_level, n_cur_level;
    logic [LEVEL_W-1:0] r_seen_level, n_seen_level;
    logic               r_pwr, n_pwr;
    logic [TIME_W-1:0]  r_last_time, n_last_time;
    logic [CNT_W-1:0]   r_on_cnt, n_on_cnt, r_off_cnt, n_off_cnt;
    logic [TIME_W-1:0]  r_on_sum, n_on_sum, r_off_sum, n_off_sum;
    logic [TIME_W-1:0]  r_on_stamp, n_on_stamp, r_off_stamp, n_off_stamp;

    logic      r_out_valid;
    t_out_item r_out_data, out_data;

    logic accept, exec_done;

    logic [ExtW-1:0]   in_lvl_ext, in_cur_ext, x_lvl_ext, x_cur_ext;
    logic              lvl_ok, cur_ok;
    logic [IdxW-1:0]   e_raddr, s_raddr;

    logic [EntW-1:0]   e_rdata, e_wdata;
    logic [TIME_W-1:0] s_rdata, s_wdata;
    logic              e_we, s_we;
    logic [CNT_W-1:0]  e_cnt;
    logic [TIME_W-1:0] e_stamp, s_sum, delta;

    assign accept = i_valid && !o_stall;

    // Read addresses: the entry table follows the event's level, the time table
    // follows the current level unless the event reads a level.
    assign in_lvl_ext = ExtW'(i_data.level);
    assign in_cur_ext = ExtW'(r_cur_level);
    assign e_raddr    = in_lvl_ext[IdxW-1:0];
    assign s_raddr    = (i_data.opcode == OP_RD_LVL) ? in_lvl_ext[IdxW-1:0]
                                                     : in_cur_ext[IdxW-1:0];

    plrc_ram #(.WIDTH(EntW), .DEPTH(NUM_LEVELS)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (r_e_addr),
        .i_wdata (e_wdata),
        .i_re    (accept),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    plrc_ram #(.WIDTH(TIME_W), .DEPTH(NUM_LEVELS)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_s_addr),
        .i_wdata (s_wdata),
        .i_re    (accept),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_stall   = 1'b1;
        exec_done = 1'b0;
        case (r_state)
            ST_IDLE: o_stall = 1'b0;
            ST_EXEC: exec_done = !r_out_valid || !i_stall;
            default: o_stall = 1'b1;
        endcase
    end

    assign x_lvl_ext = ExtW'(r_item.level);
    assign x_cur_ext = ExtW'(r_cur_level);
    assign lvl_ok    = x_lvl_ext < ExtW'(NUM_LEVELS);
    assign cur_ok    = x_cur_ext < ExtW'(NUM_LEVELS);

    // Entries never written read as zero.
    assign e_cnt   = r_e_vld[r_e_addr] ? e_rdata[EntW-1:TIME_W] : '0;
    assign e_stamp = r_e_vld[r_e_addr] ? e_rdata[TIME_W-1:0]    : '0;
    assign s_sum   = r_s_vld[r_s_addr] ? s_rdata                : '0;
    assign delta   = r_item.time_ns - r_last_time;

    assign e_wdata = {e_cnt + CNT_W'(1), r_item.time_ns};
    assign s_wdata = s_sum + delta;

    always_comb begin
        e_we         = 1'b0;
        s_we         = 1'b0;
        n_cur_level  = r_cur_level;
        n_seen_level = r_seen_level;
        n_pwr        = r_pwr;
        n_last_time  = r_last_time;
        n_on_cnt     = r_on_cnt;
        n_on_sum     = r_on_sum;
        n_on_stamp   = r_on_stamp;
        n_off_cnt    = r_off_cnt;
        n_off_sum    = r_off_sum;
        n_off_stamp  = r_off_stamp;
        out_data     = '0;
        case (r_item.opcode)
            OP_START: begin
                n_last_time = r_item.time_ns;
                n_pwr       = r_item.pwr_on;
                n_cur_level = r_item.level;
                e_we        = lvl_ok;
            end
            OP_UPDATE: begin
                if (r_pwr) begin
                    if (r_item.pwr_on) begin
                        e_we = lvl_ok && (r_item.level != r_cur_level);
                    end else begin
                        n_off_cnt   = r_off_cnt + CNT_W'(1);
                        n_off_stamp = r_item.time_ns;
                    end
                    s_we     = cur_ok;
                    n_on_sum = r_on_sum + delta;
                end else begin
                    if (r_item.pwr_on) begin
                        n_on_cnt   = r_on_cnt + CNT_W'(1);
                        n_on_stamp = r_item.time_ns;
                        e_we       = lvl_ok && (r_item.level != r_seen_level);
                    end
                    n_off_sum = r_off_sum + delta;
                end
                n_pwr        = r_item.pwr_on;
                n_last_time  = r_item.time_ns;
                n_seen_level = r_item.level;
                n_cur_level  = r_item.level;
            end
            OP_RD_LVL: begin
                if (lvl_ok) begin
                    out_data.entry_cnt = e_cnt;
                    out_data.resid_ns  = s_sum;
                    out_data.stamp_ns  = e_stamp;
                end
            end
            OP_RD_ON: begin
                out_data.entry_cnt = r_on_cnt;
                out_data.resid_ns  = r_on_sum;
                out_data.stamp_ns  = r_on_stamp;
            end
            OP_RD_OFF: begin
                out_data.entry_cnt = r_off_cnt;
                out_data.resid_ns  = r_off_sum;
                out_data.stamp_ns  = r_off_stamp;
            end
            default: out_data = '0;
        endcase
        if (!exec_done) begin
            e_we = 1'b0;
            s_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_e_vld      <= '0;
            r_s_vld      <= '0;
            r_out_valid  <= 1'b0;
            r_cur_level  <= '0;
            r_seen_level <= '0;
            r_pwr        <= 1'b0;
            r_last_time  <= '0;
            r_on_cnt     <= '0;
            r_on_sum     <= '0;
            r_on_stamp   <= '0;
            r_off_cnt    <= '0;
            r_off_sum    <= '0;
            r_off_stamp  <= '0;
        end else begin
            r_state <= n_state;
            if (e_we) begin
                r_e_vld[r_e_addr] <= 1'b1;
            end
            if (s_we) begin
                r_s_vld[r_s_addr] <= 1'b1;
            end
            if (exec_done) begin
                r_out_valid  <= 1'b1;
                r_cur_level  <= n_cur_level;
                r_seen_level <= n_seen_level;
                r_pwr        <= n_pwr;
                r_last_time  <= n_last_time;
                r_on_cnt     <= n_on_cnt;
                r_on_sum     <= n_on_sum;
                r_on_stamp   <= n_on_stamp;
                r_off_cnt    <= n_off_cnt;
                r_off_sum    <= n_off_sum;
                r_off_stamp  <= n_off_stamp;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item   <= i_data;
            r_e_addr <= e_raddr;
            r_s_addr <= s_raddr;
        end
        if (exec_done) begin
            r_out_data <= out_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

FILE: rtl/plrc_checker.sv
module plrc_checker
    import plrc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input t_in_item  i_data,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_data
);

    // A stalled result stays in place until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed or vanished");

    // The block works on one event at a time, so a transfer in makes it busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while an event was still in progress");

    // A fresh result always follows an input transfer, through the execute state.
    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall, 2))
        else $error("result appeared without a matching input transfer");

endmodule

bind power_level_residency_counters_unit plrc_checker u_plrc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
